>>> hw/rtl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared constants and types for the magnetometer min/max calibration block.
// ----------------------------------------------------------------------------
package mmc_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int SCALE_FRAC_BITS_DEF = 12;
  localparam int SCALE_W             = 28;
  localparam int AXES                = 3;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/mag_min_max_calibration.sv
// ----------------------------------------------------------------------------
// mag_min_max_calibration
// Hard/soft-iron magnetometer calibration from per-axis min/max bounds.
//
// Input channel (in_valid/in_ready): one word per sample or finish request.
// A sample word (action 0) updates the three axis lanes in the cycle it is
// accepted; samples are taken one per cycle while the block is idle.
// A finish word (action 1) produces exactly one output word: bias per axis
// (max+min), soft-iron scale per axis in unsigned fixed point, and no_data.
// Before the output register is loaded, a finish sums the chords (ST_SUM),
// then the three lane dividers run in parallel, one quotient bit per cycle.
// Empty runs and runs with a zero chord skip the dividers and go straight
// from ST_SUM to ST_DONE.
// The output register holds the word until out_ready; a stalled receiver only
// delays loading the next finish's word; samples are accepted until that
// finish is taken. A finish starts a new run. Reset empties the run and
// drops any pending output word.
// ----------------------------------------------------------------------------
module mag_min_max_calibration #(
  parameter int SAMPLE_BITS     = mmc_pkg::SAMPLE_BITS_DEF,
  parameter int SCALE_FRAC_BITS = mmc_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic signed [SAMPLE_BITS-1:0]   mag_x,
  input  logic signed [SAMPLE_BITS-1:0]   mag_y,
  input  logic signed [SAMPLE_BITS-1:0]   mag_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS:0]     bias_x,
  output logic signed [SAMPLE_BITS:0]     bias_y,
  output logic signed [SAMPLE_BITS:0]     bias_z,
  output logic [mmc_pkg::SCALE_W-1:0]     scale_x,
  output logic [mmc_pkg::SCALE_W-1:0]     scale_y,
  output logic [mmc_pkg::SCALE_W-1:0]     scale_z,
  output logic                            no_data
);
  import mmc_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int NUM_W = SUM_W + SCALE_FRAC_BITS;
  localparam int DEN_W = SAMPLE_BITS + 2;
  localparam int QW    = (NUM_W > SCALE_W) ? NUM_W : SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
  localparam logic [QW-1:0]      SCALE_MAX = QW'({SCALE_W{1'b1}});

  state_t state, state_next;

  logic have_samples;
  logic run_valid;
  logic unity;
  logic in_acc, smp_acc, fin_acc;
  logic div_start;
  logic load_out;
  logic any_zero;
  logic [SUM_W-1:0] sum;

  logic signed [SAMPLE_BITS-1:0] mag   [AXES];
  logic signed [SAMPLE_BITS:0]   bias  [AXES];
  logic        [SAMPLE_BITS-1:0] chord [AXES];
  logic        [NUM_W-1:0]       quo   [AXES];
  logic        [SCALE_W-1:0]     scale [AXES];
  logic        [AXES-1:0]        busy;

  assign mag[0] = mag_x;
  assign mag[1] = mag_y;
  assign mag[2] = mag_z;

  assign in_acc  = in_valid && in_ready;
  assign smp_acc = in_acc && action == ACT_SAMPLE;
  assign fin_acc = in_acc && action == ACT_FINISH;

  assign sum = SUM_W'(chord[0]) + SUM_W'(chord[1]) + SUM_W'(chord[2]);
  assign any_zero = chord[0] == '0 || chord[1] == '0 || chord[2] == '0;

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    logic [QW-1:0] q_ext;

    mmc_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk   (clk),
      .upd   (smp_acc),
      .seed  (!have_samples),
      .sample(mag[i]),
      .bias  (bias[i]),
      .chord (chord[i])
    );

    mmc_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
    ) u_div (
      .clk  (clk),
      .rst  (rst),
      .start(div_start),
      .num  (NUM_W'(sum) << SCALE_FRAC_BITS),
      .den  ((DEN_W'(chord[i]) << 1) + DEN_W'(chord[i])),
      .busy (busy[i]),
      .quo  (quo[i])
    );

    assign q_ext    = QW'(quo[i]);
    assign scale[i] = (q_ext > SCALE_MAX) ? {SCALE_W{1'b1}} : q_ext[SCALE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && action == ACT_FINISH) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (run_valid && !any_zero) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (busy == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_samples <= 1'b0;
    end else if (smp_acc) begin
      have_samples <= 1'b1;
    end else if (fin_acc) begin
      have_samples <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_acc) begin
      run_valid <= have_samples;
    end
    if (state == ST_SUM) begin
      unity <= any_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      no_data <= !run_valid;
      if (!run_valid) begin
        bias_x  <= '0;
        bias_y  <= '0;
        bias_z  <= '0;
        scale_x <= SCALE_ONE;
        scale_y <= SCALE_ONE;
        scale_z <= SCALE_ONE;
      end else begin
        bias_x  <= bias[0];
        bias_y  <= bias[1];
        bias_z  <= bias[2];
        scale_x <= unity ? SCALE_ONE : scale[0];
        scale_y <= unity ? SCALE_ONE : scale[1];
        scale_z <= unity ? SCALE_ONE : scale[2];
      end
    end
  end

  a_sample_sets_run: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> have_samples)
    else $error("sample did not mark the run as holding data");

  a_finish_clears_run: assert property (@(posedge clk) disable iff (rst)
    fin_acc |=> !have_samples && state == ST_SUM)
    else $error("finish did not start a new run");

  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> busy == '0 || busy == {AXES{1'b1}})
    else $error("lane dividers out of step");

  a_no_data_unity: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_data |-> scale_x == SCALE_ONE && bias_x == '0)
    else $error("empty run word carries data");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid || out_ready)
    else $error("output word overwritten before it was taken");

endmodule

>>> hw/rtl/mmc_lane.sv
// ----------------------------------------------------------------------------
// mmc_lane
// One axis: running min/max of the samples, bias (max+min) and chord (max-min).
// ----------------------------------------------------------------------------
module mmc_lane #(
  parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          upd,
  input  logic                          seed,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS:0]   bias,
  output logic        [SAMPLE_BITS-1:0] chord
);
  import mmc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] min_val;
  logic signed [SAMPLE_BITS-1:0] max_val;
  logic signed [SAMPLE_BITS:0]   diff;

  always_ff @(posedge clk) begin
    if (upd) begin
      if (seed || sample < min_val) begin
        min_val <= sample;
      end
      if (seed || sample > max_val) begin
        max_val <= sample;
      end
    end
  end

  assign bias  = (SAMPLE_BITS+1)'(max_val) + (SAMPLE_BITS+1)'(min_val);
  assign diff  = (SAMPLE_BITS+1)'(max_val) - (SAMPLE_BITS+1)'(min_val);
  assign chord = diff[SAMPLE_BITS-1:0];

endmodule

>>> hw/rtl/mmc_div.sv
// ----------------------------------------------------------------------------
// mmc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmc_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  import mmc_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign busy = cnt != '0;

endmodule
